/* hdl/u8fh_pkg.sv */
`timescale 1ns / 1ps

package u8fh_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned HASH_W  = 64;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [HASH_W-1:0] FNV_BASIS      = 64'hcbf29ce484222325;
  localparam logic [CP_W-1:0]   REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0]   UPPER_FIRST    = 21'h000041;
  localparam logic [CP_W-1:0]   UPPER_LAST     = 21'h00005A;
  localparam logic [CP_W-1:0]   CASE_OFFSET    = 21'd32;

  // Operation queue between the decoder and the hash unit.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic            is_end;
    logic [CP_W-1:0] cp;
  } u8fh_op_t;

  // Number of continuation bytes announced by a lead byte.
  function automatic logic [1:0] follow_count(input logic [BYTE_W-1:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b[7:5] == 3'b110) n = 2'd1;
    else if (b[7:4] == 4'b1110) n = 2'd2;
    else if (b[7:3] == 5'b11110) n = 2'd3;
    return n;
  endfunction

  function automatic logic [CP_W-1:0] assemble(input logic [BYTE_W-1:0] lead,
                                               input logic [BYTE_W-1:0] b1,
                                               input logic [BYTE_W-1:0] b2,
                                               input logic [BYTE_W-1:0] b3,
                                               input logic [1:0]        nd);
    logic [CP_W-1:0] cp;
    case (nd)
      2'd1:    cp = {10'd0, lead[4:0], b1[5:0]};
      2'd2:    cp = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
      2'd3:    cp = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = '0;
    endcase
    return cp;
  endfunction

  // One FNV-1a round. The prime 2^40 + 0x1b3 is applied as a sum of shifts.
  function automatic logic [HASH_W-1:0] fnv_mix(input logic [HASH_W-1:0] h,
                                                input logic [CP_W-1:0]   cp);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-CP_W){1'b0}}, cp};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

/* hdl/u8fh_byte_if.sv */
`timescale 1ns / 1ps

interface u8fh_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, data_byte, has_byte, last, input ready);
  modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

/* hdl/u8fh_hash_if.sv */
`timescale 1ns / 1ps

interface u8fh_hash_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

/* hdl/u8fh_front.sv */
`timescale 1ns / 1ps

module u8fh_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  u8fh_byte_if.sink          byte_i,
  output logic               op_valid_o,
  output u8fh_pkg::u8fh_op_t op_o,
  input  logic               op_ready_i
);
  import u8fh_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_FLUSH
  } state_e;

  state_e              state_q, state_d;
  logic [BYTE_W-1:0]   pend_q [3];
  logic [BYTE_W-1:0]   pend_d [3];
  logic [1:0]          cnt_q, cnt_d;
  logic [1:0]          pos_q, pos_d;

  logic                accept;
  logic [1:0]          nd_in, nd_lead, nd_pos;
  logic [4*BYTE_W-1:0] window;
  logic [BYTE_W-1:0]   w0, w1, w2;
  logic [1:0]          avail;

  assign accept = byte_i.valid && byte_i.ready;
  assign nd_in   = follow_count(byte_i.data_byte);
  assign nd_lead = follow_count(pend_q[0]);

  // Pending bytes seen from the flush position onwards.
  assign window = {8'd0, pend_q[2], pend_q[1], pend_q[0]} >> {pos_q, 3'b000};
  assign w0     = window[BYTE_W-1:0];
  assign w1     = window[2*BYTE_W-1:BYTE_W];
  assign w2     = window[3*BYTE_W-1:2*BYTE_W];
  assign nd_pos = follow_count(w0);
  assign avail  = cnt_q - pos_q;

  always_comb begin
    state_d      = state_q;
    pend_d       = pend_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    op_valid_o   = 1'b0;
    op_o.is_end  = 1'b0;
    op_o.cp      = '0;
    byte_i.ready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        byte_i.ready = op_ready_i;
        if (accept) begin
          if (byte_i.has_byte) begin
            if (cnt_q == 2'd0) begin
              if (nd_in == 2'd0) begin
                op_valid_o = 1'b1;
                op_o.cp    = byte_i.data_byte[7] ? REPLACEMENT_CP
                                                 : {{(CP_W-BYTE_W){1'b0}}, byte_i.data_byte};
              end else begin
                pend_d[0] = byte_i.data_byte;
                cnt_d     = 2'd1;
              end
            end else if (cnt_q == nd_lead) begin
              op_valid_o = 1'b1;
              op_o.cp    = assemble(pend_q[0],
                                    (nd_lead == 2'd1) ? byte_i.data_byte : pend_q[1],
                                    (nd_lead == 2'd2) ? byte_i.data_byte : pend_q[2],
                                    byte_i.data_byte, nd_lead);
              cnt_d      = 2'd0;
            end else begin
              pend_d[cnt_q] = byte_i.data_byte;
              cnt_d         = cnt_q + 2'd1;
            end
          end
          if (byte_i.last) begin
            state_d = ST_FLUSH;
            pos_d   = 2'd0;
          end
        end
      end

      ST_FLUSH: begin
        // Decode the cut-short tail one code point a cycle while the queue takes them, then mark the end.
        op_valid_o = 1'b1;
        if (pos_q == cnt_q) begin
          op_o.is_end = 1'b1;
          if (op_ready_i) begin
            state_d = ST_IDLE;
            cnt_d   = 2'd0;
          end
        end else begin
          if (!w0[7]) begin
            op_o.cp = {{(CP_W-BYTE_W){1'b0}}, w0};
            if (op_ready_i) pos_d = pos_q + 2'd1;
          end else if (nd_pos != 2'd0 && nd_pos < avail) begin
            op_o.cp = assemble(w0, w1, w2, 8'd0, nd_pos);
            if (op_ready_i) pos_d = pos_q + nd_pos + 2'd1;
          end else begin
            op_o.cp = REPLACEMENT_CP;
            if (op_ready_i) pos_d = pos_q + 2'd1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 2'd0;
      pos_q   <= 2'd0;
      pend_q  <= '{default: '0};
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      pend_q  <= pend_d;
    end
  end

endmodule

/* hdl/u8fh_queue.sv */
`timescale 1ns / 1ps

module u8fh_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  u8fh_pkg::u8fh_op_t in_op_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output u8fh_pkg::u8fh_op_t out_op_o,
  input  logic               out_ready_i
);
  import u8fh_pkg::*;

  u8fh_op_t           mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               push, pop;

  assign in_ready_o  = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_op_o    = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + Q_PTR_W'(1);
      if (pop)  rd_q <= rd_q + Q_PTR_W'(1);
      if (push && !pop)      cnt_q <= cnt_q + Q_CNT_W'(1);
      else if (pop && !push) cnt_q <= cnt_q - Q_CNT_W'(1);
    end
  end

endmodule

/* hdl/u8fh_back.sv */
`timescale 1ns / 1ps

module u8fh_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               op_valid_i,
  input  u8fh_pkg::u8fh_op_t op_i,
  output logic               op_ready_o,
  u8fh_hash_if.source        hash_o
);
  import u8fh_pkg::*;

  logic [HASH_W-1:0] acc_q;
  logic [HASH_W-1:0] hash_q;
  logic              out_valid_q;
  logic [CP_W-1:0]   cp_fold;
  logic              pop;

  // An end marker waits while the previous hash has not been taken.
  assign op_ready_o = !op_i.is_end || !out_valid_q || hash_o.ready;
  assign pop        = op_valid_i && op_ready_o;

  always_comb begin
    cp_fold = op_i.cp;
    if (op_i.cp inside {[UPPER_FIRST:UPPER_LAST]}) cp_fold = op_i.cp + CASE_OFFSET;
  end

  assign hash_o.valid      = out_valid_q;
  assign hash_o.hash_value = hash_q;

  always_ff @(posedge clk_i) begin
    if (pop && op_i.is_end) hash_q <= acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= FNV_BASIS;
      out_valid_q <= 1'b0;
    end else begin
      if (pop && op_i.is_end) begin
        acc_q       <= FNV_BASIS;
        out_valid_q <= 1'b1;
      end else begin
        if (pop) acc_q <= fnv_mix(acc_q, cp_fold);
        if (hash_o.ready) out_valid_q <= 1'b0;
      end
    end
  end

endmodule

/* hdl/utf8_caseless_fnv1a_hash.sv */
`timescale 1ns / 1ps

// Channel  Role  Payload                       Transfer
// byte_i   sink  data_byte, has_byte, last     valid && ready
// hash_o   src   hash_value (64 bits)          valid && ready
//
// One byte is taken per cycle while the string runs and the queue has room.
// The string's last item holds the decoder while it walks the undecoded tail
// serially, each tail code point then the end marker. The hash unit folds one
// code point per cycle from a four-entry queue unless an end marker waits on
// an untaken hash, so a brief stall on either side need not block the other.
// Reset clears all control state, reloads the FNV basis; no clearing pass needed.

module utf8_caseless_fnv1a_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8fh_byte_if.sink   byte_i,
  u8fh_hash_if.source hash_o
);
  import u8fh_pkg::*;

  logic     fr_valid, fr_ready;
  u8fh_op_t fr_op;
  logic     bk_valid, bk_ready;
  u8fh_op_t bk_op;

  u8fh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_i),
    .op_valid_o (fr_valid),
    .op_o       (fr_op),
    .op_ready_i (fr_ready)
  );

  u8fh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_op_i     (fr_op),
    .in_ready_o  (fr_ready),
    .out_valid_o (bk_valid),
    .out_op_o    (bk_op),
    .out_ready_i (bk_ready)
  );

  u8fh_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (bk_valid),
    .op_i       (bk_op),
    .op_ready_o (bk_ready),
    .hash_o     (hash_o)
  );

endmodule
